### hw/rtl/tdfsm_pkg.sv
// Package for the table-driven state machine.
// Holds the table sizes, command codes, register indexes and the row type.
// No dependencies.
package tdfsm_pkg;

   localparam int STATES_MAX = 16;
   localparam int STATE_W    = $clog2(STATES_MAX);
   localparam int COUNT_W    = STATE_W + 1;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 2 * STATE_W + 2 * BYTE_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;

   localparam logic [BYTE_W-1:0]  NO_TRANSITION = 8'hFF;
   localparam logic [COUNT_W-1:0] COUNT_MIN     = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] COUNT_MAX     = COUNT_W'(STATES_MAX);

   typedef enum logic [REQ_USER_W-1:0] {
      CMD_TICK    = 2'd0,
      CMD_WR_COND = 2'd1,
      CMD_WR_OUT  = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STATE_COUNT = 1'd0,
      CSR_INPUT_MASK  = 1'd1
   } csr_idx_type;

   typedef logic [STATES_MAX-1:0][BYTE_W-1:0] row_type;

endpackage

### hw/rtl/table_driven_fsm.sv
// Programmable table-driven state machine, top level.
// Uses tdfsm_pkg. The transition table lives in one synchronous row memory.
//
// Usage: items arrive on the req_ channel; req_tuser carries the command
// (tick, condition write, output write) and req_tdata the operands. Every
// item yields one transfer on the rsp_ channel with the present state, its
// output byte and a moved flag. The user must write the state count and
// match mask registers through csr_ only while the block is idle; the block
// itself does not enforce this. Accepting an item registers the read of one
// 16-byte transition row; in the execution state the row is matched (tick) or
// merged and written back (condition write), the state is updated and the
// result register is loaded. The block takes no new item until the previous
// one has executed.
// A stalled receiver holds the result register; one further item is accepted
// only once that result is being taken, so nothing is dropped.
// Reset at once clears the state, the row valid bits (invalid rows read zero),
// the output table and the match mask, and sets the state count to 16.
module table_driven_fsm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // src_state[3:0], dst_state[7:4], entry_value[15:8], in_bits[23:16]
   input  logic [tdfsm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd[1:0]
   input  logic [tdfsm_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cur_state[3:0], out_byte[11:4], moved[12], zero fill[15:13]
   output logic [tdfsm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [tdfsm_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [tdfsm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tdfsm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } fsm_type;

   fsm_type                st_ff, st_in;
   logic [COUNT_W-1:0]     state_count_ff;
   logic [BYTE_W-1:0]      match_mask_ff;
   logic [STATE_W-1:0]     present_ff, present_in;
   cmd_type                cmd_ff;
   logic [STATE_W-1:0]     src_ff, dst_ff;
   logic [BYTE_W-1:0]      val_ff, bits_ff;
   row_type                trans_mem [STATES_MAX];
   row_type                row_rd_ff;
   logic                   row_vld_rd_ff;
   logic [STATES_MAX-1:0]  row_vld_ff;
   logic [BYTE_W-1:0]      out_tab_ff [STATES_MAX];
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic [STATE_W-1:0]     rd_addr;
   logic [COUNT_W-1:0]     n_eff;
   row_type                row, row_merged;
   logic                   src_ok, dst_ok;
   logic                   wr_row, wr_out, hit, moved;
   logic [STATE_W-1:0]     hit_idx;
   logic [BYTE_W-1:0]      out_byte;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !reset && (st_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rd_addr    = (cmd_type'(req_tuser) == CMD_TICK) ? present_ff
                                                          : req_tdata[STATE_W-1:0];

   always_comb begin
      if (state_count_ff < COUNT_MIN) begin
         n_eff = COUNT_MIN;
      end else if (state_count_ff > COUNT_MAX) begin
         n_eff = COUNT_MAX;
      end else begin
         n_eff = state_count_ff;
      end
   end

   assign row    = row_vld_rd_ff ? row_rd_ff : '0;
   assign src_ok = {1'b0, src_ff} < n_eff;
   assign dst_ok = {1'b0, dst_ff} < n_eff;
   assign wr_row = (st_ff == ST_EXEC) && (cmd_ff == CMD_WR_COND) && src_ok && dst_ok;
   assign wr_out = (st_ff == ST_EXEC) && (cmd_ff == CMD_WR_OUT) && src_ok;

   always_comb begin
      row_merged         = row;
      row_merged[dst_ff] = val_ff;
   end

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int t = STATES_MAX - 1; t >= 0; t--) begin
         if ((COUNT_W'(t) < n_eff) && (row[t] != NO_TRANSITION)
             && ((row[t] & match_mask_ff) == (bits_ff & match_mask_ff))) begin
            hit     = 1'b1;
            hit_idx = STATE_W'(t);
         end
      end
   end

   always_comb begin
      st_in      = st_ff;
      present_in = present_ff;
      moved      = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               st_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            st_in = ST_IDLE;
            if ((cmd_ff == CMD_TICK) && hit) begin
               present_in = hit_idx;
               moved      = (hit_idx != present_ff);
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (wr_out && (src_ff == present_in)) begin
         out_byte = val_ff;
      end else begin
         out_byte = out_tab_ff[present_in];
      end
      rsp_data_in = {3'b000, moved, out_byte, present_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff          <= ST_IDLE;
         present_ff     <= '0;
         state_count_ff <= COUNT_MAX;
         match_mask_ff  <= '0;
         row_vld_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < STATES_MAX; i++) begin
            out_tab_ff[i] <= '0;
         end
      end else begin
         st_ff      <= st_in;
         present_ff <= present_in;
         if (csr_wr_en) begin
            case (csr_idx_type'(csr_addr))
               CSR_STATE_COUNT: state_count_ff <= csr_wdata[COUNT_W-1:0];
               CSR_INPUT_MASK:  match_mask_ff  <= csr_wdata;
               default:         state_count_ff <= state_count_ff;
            endcase
         end
         if (wr_row) begin
            row_vld_ff[src_ff] <= 1'b1;
         end
         if (wr_out) begin
            out_tab_ff[src_ff] <= val_ff;
         end
         if (st_ff == ST_EXEC) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= cmd_type'(req_tuser);
         src_ff        <= req_tdata[STATE_W-1:0];
         dst_ff        <= req_tdata[2*STATE_W-1:STATE_W];
         val_ff        <= req_tdata[2*STATE_W+BYTE_W-1:2*STATE_W];
         bits_ff       <= req_tdata[2*STATE_W+2*BYTE_W-1:2*STATE_W+BYTE_W];
         row_rd_ff     <= trans_mem[rd_addr];
         row_vld_rd_ff <= row_vld_ff[rd_addr];
      end
      if (wr_row) begin
         trans_mem[src_ff] <= row_merged;
      end
      if (st_ff == ST_EXEC) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (st_ff == ST_EXEC))
      else $error("accepted item did not enter execution");

   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_EXEC) |=> rsp_valid_ff)
      else $error("execution did not load a result");

   a_exec_room: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_EXEC) |-> !rsp_valid_ff)
      else $error("result register still occupied at execution");

   a_write_no_move: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == ST_EXEC) && (cmd_ff != CMD_TICK)) |=> !rsp_data_ff[12])
      else $error("non-tick item reported a move");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_EXEC) |=> $stable(present_ff))
      else $error("state changed outside execution");
`endif

endmodule

### verif/tb_table_driven_fsm.sv
// Self-checking testbench for table_driven_fsm: directed and random command streams
// with random idling on both stream sides, checked against a behavioral predictor.
// Depends on tdfsm_pkg and table_driven_fsm.
module tb_table_driven_fsm;
   timeunit 1ns;
   timeprecision 1ps;

   import tdfsm_pkg::*;

   localparam int SIDE_REQ = 0;
   localparam int SIDE_RSP = 1;
   localparam int PHASE_ITEMS = 170;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] bits;
      logic [7:0] value;
      logic [3:0] dst;
      logic [3:0] src;
   } fsm_item_type;

   typedef struct packed {
      logic [3:0] state;
      logic [7:0] out_byte;
      logic       moved;
   } fsm_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = CMD_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = CSR_STATE_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   fsm_item_type   fsm_cmds_q [$];
   fsm_result_type fsm_outcomes_q [$];
   fsm_item_type   next_item;
   fsm_result_type rsp_want;
   int unsigned req_gap = 0;
   int unsigned rsp_wait = 0;
   int unsigned rsp_stall;
   int unsigned error_count = 0;
   int unsigned stretch_left [2] = '{0, 0};
   bit          stretch_calm [2] = '{1'b0, 1'b0};

   logic [3:0]  fsm_state = '0;
   logic [7:0]  cond_tab [16][16];
   logic [7:0]  out_tab [16];
   logic [4:0]  count_reg = 5'd16;
   logic [7:0]  mask_reg = 8'h00;
   logic [7:0]  cond_pool [4];

   table_driven_fsm uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic int unsigned draw_wait(int side);
      if (stretch_left[side] == 0) begin
         stretch_left[side] = $urandom_range(8, 40);
         stretch_calm[side] = ($urandom_range(0, 2) == 0);
      end
      stretch_left[side]--;
      return stretch_calm[side] ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic int unsigned eff_count();
      if (count_reg < 5'd2) begin
         return 2;
      end
      if (count_reg > 5'd16) begin
         return 16;
      end
      return count_reg;
   endfunction

   function automatic fsm_result_type advance_fsm(fsm_item_type it);
      fsm_result_type r;
      int unsigned    n;
      logic [3:0]     target_state;
      bit             found;
      n = eff_count();
      r.moved = 1'b0;
      case (it.cmd)
         CMD_WR_COND: begin
            if (it.src < n && it.dst < n) cond_tab[it.src][it.dst] = it.value;
         end
         CMD_WR_OUT: begin
            if (it.src < n) out_tab[it.src] = it.value;
         end
         CMD_TICK: begin
            target_state = fsm_state;
            found = 1'b0;
            for (int t = 0; t < n; t++) begin
               if (!found && cond_tab[fsm_state][t] != NO_TRANSITION &&
                   ((cond_tab[fsm_state][t] ^ it.bits) & mask_reg) == 8'h00) begin
                  target_state = 4'(t);
                  found = 1'b1;
               end
            end
            r.moved = (target_state != fsm_state);
            fsm_state = target_state;
         end
         default: begin
         end
      endcase
      r.state = fsm_state;
      r.out_byte = out_tab[fsm_state];
      return r;
   endfunction

   function automatic fsm_item_type make_item(cmd_type cmd, int unsigned src,
                                              int unsigned dst, int unsigned value,
                                              int unsigned bits);
      fsm_item_type it;
      it.cmd = cmd;
      it.src = 4'(src);
      it.dst = 4'(dst);
      it.value = 8'(value);
      it.bits = 8'(bits);
      return it;
   endfunction

   // Operands mostly come from a small pool of condition values so that ticks
   // hit programmed entries; bits outside the mask are scrambled.
   function automatic fsm_item_type random_item();
      fsm_item_type it;
      int unsigned  n;
      int unsigned  pick;
      n = eff_count();
      pick = $urandom_range(0, 99);
      it.src = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, n - 1));
      it.dst = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, n - 1));
      it.value = cond_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 9) == 0) it.value = 8'($urandom);
      it.bits = cond_pool[$urandom_range(0, 3)] ^ (8'($urandom) & ~mask_reg);
      if ($urandom_range(0, 6) == 0) it.bits = 8'($urandom);
      if (pick < 55) begin
         it.cmd = CMD_TICK;
      end else if (pick < 80) begin
         it.cmd = CMD_WR_COND;
      end else if (pick < 86) begin
         it.cmd = CMD_WR_COND;
         it.value = NO_TRANSITION;
      end else if (pick < 95) begin
         it.cmd = CMD_WR_OUT;
         it.value = 8'($urandom);
      end else begin
         it.cmd = CMD_NONE;
      end
      return it;
   endfunction

   task automatic write_csr(csr_idx_type idx, logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_STATE_COUNT) begin
         count_reg = value[4:0];
      end else begin
         mask_reg = value;
      end
   endtask

   task automatic wait_idle();
      int unsigned spent;
      spent = 0;
      while ((fsm_cmds_q.size() > 0 || req_tvalid || fsm_outcomes_q.size() > 0) &&
             spent < 100000) begin
         @(posedge clock);
         spent++;
      end
      if (fsm_outcomes_q.size() > 0) begin
         report_mismatch("results never delivered", fsm_outcomes_q.size(), 0);
         fsm_outcomes_q.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            fsm_outcomes_q.push_back(advance_fsm(fsm_item_type'({req_tuser, req_tdata})));
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (fsm_cmds_q.size() > 0) begin
            next_item = fsm_cmds_q.pop_front();
            {req_tuser, req_tdata} <= next_item;
            req_tvalid <= 1'b1;
            req_gap <= draw_wait(SIDE_REQ);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fsm_outcomes_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               rsp_want = fsm_outcomes_q.pop_front();
               if (rsp_tdata[3:0] != rsp_want.state)
                  report_mismatch("cur_state", rsp_tdata[3:0], rsp_want.state);
               if (rsp_tdata[11:4] != rsp_want.out_byte)
                  report_mismatch("out_byte", rsp_tdata[11:4], rsp_want.out_byte);
               if (rsp_tdata[12] != rsp_want.moved)
                  report_mismatch("moved", rsp_tdata[12], rsp_want.moved);
            end
            rsp_stall = draw_wait(SIDE_RSP);
            rsp_wait <= rsp_stall;
            rsp_tready <= (rsp_stall == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_tready <= (rsp_wait == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("table_driven_fsm verification failed");
      $finish;
   end

   initial begin
      int unsigned phase_count [8] = '{16, 2, 31, 0, 5, 1, 12, 16};
      logic [7:0]  phase_mask [8] = '{8'hFF, 8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 8'h00, 8'hF0};
      logic [7:0]  mask_val;

      for (int s = 0; s < 16; s++) begin
         out_tab[s] = 8'h00;
         for (int t = 0; t < 16; t++) cond_tab[s][t] = 8'h00;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // With a zero mask every entry other than the no-transition code matches.
      fsm_cmds_q.push_back(make_item(CMD_TICK, 0, 0, 0, 8'h00));
      fsm_cmds_q.push_back(make_item(CMD_TICK, 0, 0, 0, 8'hFF));
      fsm_cmds_q.push_back(make_item(CMD_NONE, 15, 15, 8'hFF, 8'hFF));
      fsm_cmds_q.push_back(make_item(CMD_WR_OUT, 0, 0, 8'hA5, 0));
      fsm_cmds_q.push_back(make_item(CMD_WR_OUT, 15, 0, 8'hFF, 0));
      fsm_cmds_q.push_back(make_item(CMD_WR_OUT, 1, 0, 8'h5A, 0));
      fsm_cmds_q.push_back(make_item(CMD_WR_COND, 0, 0, NO_TRANSITION, 0));
      fsm_cmds_q.push_back(make_item(CMD_TICK, 0, 0, 0, 8'h5A));
      wait_idle();

      // Full mask: exact matches only, a jump to the highest state.
      write_csr(CSR_INPUT_MASK, 8'hFF);
      fsm_cmds_q.push_back(make_item(CMD_WR_COND, 1, 0, 8'h11, 0));
      fsm_cmds_q.push_back(make_item(CMD_WR_COND, 1, 15, 8'h80, 0));
      fsm_cmds_q.push_back(make_item(CMD_TICK, 0, 0, 0, 8'h80));
      fsm_cmds_q.push_back(make_item(CMD_TICK, 0, 0, 0, 8'h81));
      wait_idle();

      // Shrink the count while sitting in state 15; writes past the count are dropped.
      write_csr(CSR_STATE_COUNT, 8'hE3);
      fsm_cmds_q.push_back(make_item(CMD_WR_COND, 3, 0, 8'h00, 0));
      fsm_cmds_q.push_back(make_item(CMD_WR_COND, 0, 3, 8'h00, 0));
      fsm_cmds_q.push_back(make_item(CMD_WR_OUT, 3, 0, 8'h77, 0));
      fsm_cmds_q.push_back(make_item(CMD_WR_OUT, 2, 0, 8'h33, 0));
      fsm_cmds_q.push_back(make_item(CMD_TICK, 0, 0, 0, 8'h01));
      fsm_cmds_q.push_back(make_item(CMD_WR_COND, 15, 1, 8'h01, 0));
      fsm_cmds_q.push_back(make_item(CMD_TICK, 0, 0, 0, 8'h00));
      fsm_cmds_q.push_back(make_item(CMD_TICK, 0, 0, 0, 8'h00));
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         mask_val = phase_mask[p];
         if (p == 2 || p == 6) mask_val = 8'($urandom_range(1, 254));
         write_csr(CSR_STATE_COUNT, {3'($urandom_range(0, 7)), 5'(phase_count[p])});
         write_csr(CSR_INPUT_MASK, mask_val);
         for (int k = 0; k < 4; k++) cond_pool[k] = 8'($urandom);
         if ($urandom_range(0, 1) == 0) cond_pool[0] = 8'h00;
         for (int k = 0; k < PHASE_ITEMS; k++) fsm_cmds_q.push_back(random_item());
         wait_idle();
      end

      if (error_count == 0) begin
         $display("table_driven_fsm verification clean");
      end else begin
         $display("table_driven_fsm verification failed");
      end
      $finish;
   end

endmodule
